// ===== rtl/satc_pkg.sv =====
// ----------------------------------------------------------------------------
// satc_pkg
// Types and constants shared by the set-associative cache tag controller.
// ----------------------------------------------------------------------------
`default_nettype none

package satc_pkg;

  localparam int ACTION_W   = 2;
  localparam int ADDR_W     = 32;
  localparam int WAY_OUT_W  = 3;
  localparam int MEM_WR_W   = 2;
  localparam int DCOUNT_W   = 13;
  localparam int USE_W      = 16;
  localparam int LFSR_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;
  localparam int POL_W      = 2;

  localparam logic [DCOUNT_W-1:0] DCOUNT_MAX = 13'd8191;
  localparam logic [USE_W-1:0]    USE_MAX    = 16'hFFFF;
  localparam logic [LFSR_W-1:0]   LFSR_SEED  = 16'hACE1;

  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_POLICY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_POLICY = 1'b1;

  localparam logic WP_THROUGH = 1'b0;
  localparam logic WP_BACK    = 1'b1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_COUNT = 2'd2
  } action_e;

  typedef enum logic [POL_W-1:0] {
    POL_LFU    = 2'd0,
    POL_LRU    = 2'd1,
    POL_RANDOM = 2'd2
  } repl_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/satc_req_if.sv =====
// ----------------------------------------------------------------------------
// satc_req_if
// Request channel: one cache action with its byte address per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface satc_req_if;
  logic                              valid;
  logic                              ready;
  logic [satc_pkg::ACTION_W-1:0]     action;
  logic [satc_pkg::ADDR_W-1:0]       address;

  modport source (output valid, output action, output address, input ready);
  modport sink   (input valid, input action, input address, output ready);
endinterface

`default_nettype wire

// ===== rtl/satc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// satc_rsp_if
// Response channel: hit, way, memory traffic and dirty line count per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface satc_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic [satc_pkg::WAY_OUT_W-1:0]    way;
  logic                              mem_reads;
  logic [satc_pkg::MEM_WR_W-1:0]     mem_writes;
  logic [satc_pkg::DCOUNT_W-1:0]     dirty_count;

  modport source (output valid, output hit, output way, output mem_reads,
                  output mem_writes, output dirty_count, input ready);
  modport sink   (input valid, input hit, input way, input mem_reads,
                  input mem_writes, input dirty_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/set_assoc_cache_tag_controller.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller
// Tag and policy controller of a set-associative cache (LFU, LRU, random).
// ----------------------------------------------------------------------------
// Flow: the set row is read when the item is taken; in the lookup state the compare,
//   victim choice, result register and, for accesses, write-back of the set row (one
//   RAM port pair) follow once the output is free. No new item is taken before then.
// Reset: a clearing sweep writes every set row, no item taken.
// Dirty line count is kept in a running counter, so the count action goes through
//   the same read and lookup states as an access.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_tag_controller #(
  parameter int WAYS       = 2,
  parameter int SETS       = 128,
  parameter int LINE_BYTES = 64,
  parameter int ADDR_BITS  = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  satc_req_if.sink                              req,
  satc_rsp_if.source                            rsp,
  input  wire logic                             cfg_we_i,
  input  wire logic [satc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [satc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int IDX_W  = $clog2(SETS);
  localparam int SET_W  = (IDX_W > 0) ? IDX_W : 1;
  localparam int TAG_W  = ADDR_BITS - OFF_W - IDX_W;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LINES  = SETS * WAYS;
  localparam int CNT_W  = $clog2(LINES + 1);
  localparam int SAT_W  = (CNT_W > satc_pkg::DCOUNT_W) ? CNT_W : satc_pkg::DCOUNT_W;
  localparam int USE_W  = satc_pkg::USE_W;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
    logic [WAY_W-1:0] rank;
    logic [USE_W-1:0] uses;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  // x mod WAYS for WAYS up to 8, one nibble at a time
  function automatic logic [WAY_W-1:0] mod_ways(input logic [satc_pkg::LFSR_W-1:0] x);
    logic [7:0] r;
    logic [7:0] v;
    r = '0;
    for (int n = 3; n >= 0; n--) begin
      v = {r[3:0], x[4*n +: 4]};
      for (int k = 3; k >= 0; k--) begin
        if (v >= 8'(WAYS << k)) begin
          v = v - 8'(WAYS << k);
        end
      end
      r = v;
    end
    return WAY_W'(r);
  endfunction

  satc_pkg::state_e state_q, state_d;

  logic [SET_W-1:0]                  clr_q, clr_d;
  logic [satc_pkg::ACTION_W-1:0]     act_q;
  logic [SET_W-1:0]                  set_q;
  logic [TAG_W-1:0]                  tag_q;
  logic                              wp_q;
  logic [satc_pkg::POL_W-1:0]        rp_q;
  logic [satc_pkg::LFSR_W-1:0]       lfsr_q, lfsr_d;
  logic [WAY_W-1:0]                  rnd_way_q;
  logic [CNT_W-1:0]                  dcnt_q, dcnt_d;

  logic                              out_valid_q, out_valid_d;
  logic                              out_hit_q, out_hit_d;
  logic [satc_pkg::WAY_OUT_W-1:0]    out_way_q, out_way_d;
  logic                              out_rd_q, out_rd_d;
  logic [satc_pkg::MEM_WR_W-1:0]     out_wr_q, out_wr_d;
  logic [satc_pkg::DCOUNT_W-1:0]     out_dc_q, out_dc_d;

  logic                              acc;
  logic                              out_free;
  logic [ADDR_BITS-1:0]              addr_m;
  logic [SET_W-1:0]                  set_in;
  logic [TAG_W-1:0]                  tag_in;
  logic [satc_pkg::LFSR_W-1:0]       lfsr_nx;

  logic                              ram_we, ram_re;
  logic [SET_W-1:0]                  ram_waddr;
  logic [ROW_W-1:0]                  ram_wdata, ram_rdata;

  row_t                              row, nrow, clr_row;
  logic                              is_acc, is_wr, set_dirty, hit, commit;
  logic [WAY_W-1:0]                  hway, vict, way_sel;
  logic [USE_W-1:0]                  best;
  logic [WAY_W-1:0]                  old_rank;
  logic [satc_pkg::MEM_WR_W-1:0]     writes;
  logic [SAT_W-1:0]                  dcnt_ext;
  logic [satc_pkg::DCOUNT_W-1:0]     dcnt_sat;

  assign acc      = req.valid && req.ready;
  assign out_free = !out_valid_q || rsp.ready;
  assign addr_m   = req.address[ADDR_BITS-1:0];
  assign set_in   = SET_W'((addr_m >> OFF_W) & ADDR_BITS'(SETS - 1));
  assign tag_in   = TAG_W'(addr_m >> (OFF_W + IDX_W));
  assign lfsr_nx  = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};

  satc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (set_in),
    .rdata_o (ram_rdata)
  );

  // set lookup, victim choice and row update
  always_comb begin
    row      = row_t'(ram_rdata);
    is_acc   = (act_q == satc_pkg::ACT_READ) || (act_q == satc_pkg::ACT_WRITE);
    is_wr    = (act_q == satc_pkg::ACT_WRITE);
    set_dirty = is_wr && (wp_q == satc_pkg::WP_BACK);

    hit  = 1'b0;
    hway = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!hit && row[i].valid && (row[i].tag == tag_q)) begin
        hit  = 1'b1;
        hway = WAY_W'(i);
      end
    end

    vict = '0;
    best = row[0].uses;
    unique case (rp_q)
      satc_pkg::POL_LFU: begin
        for (int i = 1; i < WAYS; i++) begin
          if (row[i].uses < best) begin
            best = row[i].uses;
            vict = WAY_W'(i);
          end
        end
      end
      satc_pkg::POL_LRU: begin
        for (int i = 0; i < WAYS; i++) begin
          if (row[i].rank == '0) begin
            vict = WAY_W'(i);
          end
        end
      end
      satc_pkg::POL_RANDOM: begin
        vict = rnd_way_q;
      end
      default: begin
        vict = '0;
      end
    endcase

    way_sel  = hit ? hway : vict;
    old_rank = row[way_sel].rank;

    nrow = row;
    for (int i = 0; i < WAYS; i++) begin
      if (WAY_W'(i) == way_sel) begin
        nrow[i].rank = WAY_W'(WAYS - 1);
      end else if (row[i].rank > old_rank) begin
        nrow[i].rank = row[i].rank - WAY_W'(1);
      end
    end

    writes = satc_pkg::MEM_WR_W'(is_wr && (wp_q == satc_pkg::WP_THROUGH));
    if (hit) begin
      if (row[way_sel].uses != satc_pkg::USE_MAX) begin
        nrow[way_sel].uses = row[way_sel].uses + USE_W'(1);
      end
      nrow[way_sel].dirty = row[way_sel].dirty | set_dirty;
      dcnt_d = dcnt_q + CNT_W'(set_dirty && !row[way_sel].dirty);
    end else begin
      nrow[way_sel].valid = 1'b1;
      nrow[way_sel].tag   = tag_q;
      nrow[way_sel].dirty = set_dirty;
      nrow[way_sel].uses  = USE_W'(1);
      writes = writes + satc_pkg::MEM_WR_W'(row[way_sel].dirty);
      dcnt_d = dcnt_q - CNT_W'(row[way_sel].dirty) + CNT_W'(set_dirty);
    end

    for (int i = 0; i < WAYS; i++) begin
      clr_row[i].tag   = '0;
      clr_row[i].valid = 1'b0;
      clr_row[i].dirty = 1'b0;
      clr_row[i].rank  = WAY_W'(i);
      clr_row[i].uses  = '0;
    end

    dcnt_ext = SAT_W'(dcnt_q);
    dcnt_sat = (dcnt_ext > SAT_W'(satc_pkg::DCOUNT_MAX)) ? satc_pkg::DCOUNT_MAX
                                                         : satc_pkg::DCOUNT_W'(dcnt_ext);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      satc_pkg::S_CLEAR: begin
        if (clr_q == SET_W'(SETS - 1)) begin
          state_d = satc_pkg::S_IDLE;
        end
      end
      satc_pkg::S_IDLE: begin
        if (acc) begin
          state_d = satc_pkg::S_LOOK;
        end
      end
      satc_pkg::S_LOOK: begin
        if (out_free) begin
          state_d = satc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = satc_pkg::S_CLEAR;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready   = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = set_q;
    ram_wdata   = nrow;
    clr_d       = clr_q;
    commit      = 1'b0;
    unique case (state_q)
      satc_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = clr_row;
        clr_d     = clr_q + SET_W'(1);
      end
      satc_pkg::S_IDLE: begin
        req.ready = 1'b1;
        ram_re    = acc;
      end
      satc_pkg::S_LOOK: begin
        commit = out_free;
        ram_we = out_free && is_acc;
      end
      default: begin
        clr_d = '0;
      end
    endcase
  end

  // result register and policy state
  always_comb begin
    out_valid_d = out_valid_q && !rsp.ready;
    out_hit_d   = out_hit_q;
    out_way_d   = out_way_q;
    out_rd_d    = out_rd_q;
    out_wr_d    = out_wr_q;
    out_dc_d    = out_dc_q;
    lfsr_d      = lfsr_q;
    if (commit) begin
      out_valid_d = 1'b1;
      out_hit_d   = 1'b0;
      out_way_d   = '0;
      out_rd_d    = 1'b0;
      out_wr_d    = '0;
      out_dc_d    = '0;
      if (is_acc) begin
        out_hit_d = hit;
        out_way_d = satc_pkg::WAY_OUT_W'(way_sel);
        out_rd_d  = !hit;
        out_wr_d  = writes;
        if (!hit && (rp_q == satc_pkg::POL_RANDOM)) begin
          lfsr_d = lfsr_nx;
        end
      end else if (act_q == satc_pkg::ACT_COUNT) begin
        out_dc_d = dcnt_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= satc_pkg::S_CLEAR;
      clr_q       <= '0;
      wp_q        <= satc_pkg::WP_THROUGH;
      rp_q        <= satc_pkg::POL_LRU;
      lfsr_q      <= satc_pkg::LFSR_SEED;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      lfsr_q      <= lfsr_d;
      out_valid_q <= out_valid_d;
      if (commit && is_acc) begin
        dcnt_q <= dcnt_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          satc_pkg::CFG_WRITE_POLICY:   wp_q <= cfg_data_i[0];
          satc_pkg::CFG_REPLACE_POLICY: rp_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      act_q <= req.action;
      set_q <= set_in;
      tag_q <= tag_in;
    end
    rnd_way_q <= (((WAYS & (WAYS - 1)) == 0) ? WAY_W'(lfsr_nx & satc_pkg::LFSR_W'(WAYS - 1))
                                             : mod_ways(lfsr_nx));
    out_hit_q <= out_hit_d;
    out_way_q <= out_way_d;
    out_rd_q  <= out_rd_d;
    out_wr_q  <= out_wr_d;
    out_dc_q  <= out_dc_d;
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.hit         = out_hit_q;
  assign rsp.way         = out_way_q;
  assign rsp.mem_reads   = out_rd_q;
  assign rsp.mem_writes  = out_wr_q;
  assign rsp.dirty_count = out_dc_q;

endmodule

`default_nettype wire

// ===== rtl/satc_ram.sv =====
// ----------------------------------------------------------------------------
// satc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module satc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic                                        re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== tb/tb_set_assoc_cache_tag_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_tag_controller
// Self-checking bench for the cache tag controller. A queue-fed driver sends
// read, write, count and unused actions with random gaps. A monitor keeps its
// own copy of tags, valid, dirty, recency ranks, use counts and the LFSR,
// predicts every result and checks it against the response channel. The run
// steps through all write and replacement policy settings.
// ----------------------------------------------------------------------------

module tb_set_assoc_cache_tag_controller;

  localparam int WAYS        = 2;
  localparam int SETS        = 128;
  localparam int LINE_BYTES  = 64;
  localparam int NLINES      = SETS * WAYS;
  localparam int OFS_W       = 6;
  localparam int SET_W       = 7;
  localparam int TAG_W       = satc_pkg::ADDR_W - OFS_W - SET_W;
  localparam int PHASE_ITEMS = 200;
  localparam int CYCLE_LIMIT = 1000000;

  localparam logic [satc_pkg::ACTION_W-1:0] ACT_NONE   = 2'd3;
  localparam logic [satc_pkg::POL_W-1:0]    POL_UNUSED = 2'd3;

  typedef struct packed {
    logic                           hit;
    logic [satc_pkg::WAY_OUT_W-1:0] way;
    logic                           mem_reads;
    logic [satc_pkg::MEM_WR_W-1:0]  mem_writes;
    logic [satc_pkg::DCOUNT_W-1:0]  dirty_count;
  } rsp_t;

  typedef struct {
    logic [satc_pkg::ACTION_W-1:0] action;
    logic [satc_pkg::ADDR_W-1:0]   address;
  } req_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [satc_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [satc_pkg::CFG_DATA_W-1:0] cfg_data_i;

  satc_req_if req_ch ();
  satc_rsp_if rsp_ch ();

  set_assoc_cache_tag_controller #(
    .WAYS       (WAYS),
    .SETS       (SETS),
    .LINE_BYTES (LINE_BYTES),
    .ADDR_BITS  (satc_pkg::ADDR_W)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // cache image
  logic [TAG_W-1:0]           line_tag   [NLINES];
  logic                       line_valid [NLINES];
  logic                       line_dirty [NLINES];
  logic [2:0]                 line_rank  [NLINES];
  logic [satc_pkg::USE_W-1:0] line_uses  [NLINES];
  logic [satc_pkg::LFSR_W-1:0] lfsr;
  logic                        wr_back;
  logic [satc_pkg::POL_W-1:0]  repl_pol;

  req_item_t pending_reqs[$];
  rsp_t      rsp_expected[$];
  req_item_t next_req;
  rsp_t      got, want;

  logic req_fire = 1'b0;
  logic rsp_fire = 1'b0;
  int unsigned req_gap = 0, req_quiet = 0;
  int unsigned rsp_hold = 0, rsp_quiet = 0;
  int unsigned cycles = 0, errors = 0, n_reported = 0;
  int unsigned n_access = 0, n_hits = 0, n_counts = 0;
  int unsigned n_writebacks = 0, n_double = 0, n_settings = 1;

  logic [SET_W-1:0] hot_set [4];
  logic [TAG_W-1:0] hot_tag [3];

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic void refresh_rank(int unsigned base, int unsigned w);
    logic [2:0] old;
    int unsigned i;
    old = line_rank[base + w];
    for (i = 0; i < WAYS; i++) begin
      if (line_rank[base + i] > old) line_rank[base + i]--;
    end
    line_rank[base + w] = 3'(WAYS - 1);
  endfunction

  function automatic rsp_t predict_access(logic [satc_pkg::ACTION_W-1:0] act,
                                          logic [satc_pkg::ADDR_W-1:0] addr);
    rsp_t r;
    int unsigned set_idx, base, w, i, dcnt;
    logic [TAG_W-1:0] tag;
    logic [satc_pkg::USE_W-1:0] best;
    logic fb;
    bit found;
    r = '0;
    if (act == ACT_NONE) return r;
    if (act == satc_pkg::ACT_COUNT) begin
      dcnt = 0;
      for (i = 0; i < NLINES; i++) dcnt += line_dirty[i];
      r.dirty_count = (dcnt > satc_pkg::DCOUNT_MAX) ? satc_pkg::DCOUNT_MAX
                                                    : satc_pkg::DCOUNT_W'(dcnt);
      n_counts++;
      return r;
    end
    n_access++;
    set_idx = addr[OFS_W +: SET_W];
    tag     = addr[satc_pkg::ADDR_W-1 -: TAG_W];
    base    = set_idx * WAYS;
    found   = 1'b0;
    w       = 0;
    for (i = 0; i < WAYS; i++) begin
      if (!found && line_valid[base + i] && line_tag[base + i] == tag) begin
        found = 1'b1;
        w = i;
      end
    end
    if (found) begin
      n_hits++;
      refresh_rank(base, w);
      if (line_uses[base + w] != satc_pkg::USE_MAX) line_uses[base + w]++;
      if (act == satc_pkg::ACT_WRITE) begin
        if (wr_back == satc_pkg::WP_BACK) line_dirty[base + w] = 1'b1;
        else r.mem_writes = satc_pkg::MEM_WR_W'(1);
      end
    end else begin
      case (repl_pol)
        satc_pkg::POL_LFU: begin
          best = line_uses[base];
          for (i = 1; i < WAYS; i++) begin
            if (line_uses[base + i] < best) begin
              best = line_uses[base + i];
              w = i;
            end
          end
        end
        satc_pkg::POL_LRU: begin
          for (i = 0; i < WAYS; i++) begin
            if (line_rank[base + i] == 0) w = i;
          end
        end
        satc_pkg::POL_RANDOM: begin
          fb = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
          lfsr = {fb, lfsr[satc_pkg::LFSR_W-1:1]};
          w = lfsr % WAYS;
        end
        default: w = 0;
      endcase
      if (line_dirty[base + w]) begin
        r.mem_writes = satc_pkg::MEM_WR_W'(1);
        n_writebacks++;
      end
      r.mem_reads = 1'b1;
      line_valid[base + w] = 1'b1;
      line_tag[base + w]   = tag;
      line_dirty[base + w] = 1'b0;
      line_uses[base + w]  = satc_pkg::USE_W'(1);
      refresh_rank(base, w);
      if (act == satc_pkg::ACT_WRITE) begin
        if (wr_back == satc_pkg::WP_BACK) line_dirty[base + w] = 1'b1;
        else r.mem_writes = r.mem_writes + 1'b1;
      end
    end
    if (r.mem_writes == 2) n_double++;
    r.hit = found;
    r.way = satc_pkg::WAY_OUT_W'(w);
    return r;
  endfunction

  // driver: request side
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      if (req_gap > 0) begin
        req_gap--;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        next_req = pending_reqs.pop_front();
        req_ch.valid   <= 1'b1;
        req_ch.action  <= next_req.action;
        req_ch.address <= next_req.address;
        if (req_quiet > 0) begin
          req_quiet--;
        end else begin
          req_gap = idle_len();
          if ($urandom_range(0, 49) == 0) req_quiet = $urandom_range(20, 60);
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // driver: response back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else if (rsp_hold > 0) begin
      rsp_hold--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (rsp_fire && rsp_quiet > 0) begin
        rsp_quiet--;
      end else if (rsp_fire || $urandom_range(0, 9) == 0) begin
        rsp_hold = idle_len();
        if ($urandom_range(0, 49) == 0) rsp_quiet = $urandom_range(20, 60);
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    req_fire <= rst_ni && req_ch.valid && req_ch.ready;
    rsp_fire <= rst_ni && rsp_ch.valid && rsp_ch.ready;
    if (rst_ni) begin
      cycles++;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          satc_pkg::CFG_WRITE_POLICY:   wr_back  = cfg_data_i[0];
          satc_pkg::CFG_REPLACE_POLICY: repl_pol = cfg_data_i;
          default: ;
        endcase
      end
      if (req_ch.valid && req_ch.ready)
        rsp_expected.push_back(predict_access(req_ch.action, req_ch.address));
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.hit         = rsp_ch.hit;
        got.way         = rsp_ch.way;
        got.mem_reads   = rsp_ch.mem_reads;
        got.mem_writes  = rsp_ch.mem_writes;
        got.dirty_count = rsp_ch.dirty_count;
        if (rsp_expected.size() == 0) begin
          errors++;
          if (n_reported < 10) begin
            n_reported++;
            $display("[%0d] unexpected item: hit=%0d way=%0d rd=%0d wr=%0d dirty=%0d",
                     cycles, got.hit, got.way, got.mem_reads, got.mem_writes,
                     got.dirty_count);
          end
        end else begin
          want = rsp_expected.pop_front();
          if (got !== want) begin
            errors++;
            if (n_reported < 10) begin
              n_reported++;
              $display("[%0d] mismatch: exp hit=%0d way=%0d rd=%0d wr=%0d dirty=%0d",
                       cycles, want.hit, want.way, want.mem_reads, want.mem_writes,
                       want.dirty_count);
              $display("[%0d]           got hit=%0d way=%0d rd=%0d wr=%0d dirty=%0d",
                       cycles, got.hit, got.way, got.mem_reads, got.mem_writes,
                       got.dirty_count);
            end
          end
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d items outstanding", cycles,
                 rsp_expected.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic push_req(logic [satc_pkg::ACTION_W-1:0] act,
                          logic [satc_pkg::ADDR_W-1:0] addr);
    req_item_t it;
    it.action  = act;
    it.address = addr;
    pending_reqs.push_back(it);
  endtask

  // mostly accesses to a few hot sets and tags, some stray addresses
  task automatic push_random(int unsigned n);
    int unsigned done, r, i;
    logic [satc_pkg::ACTION_W-1:0] act;
    logic [satc_pkg::ADDR_W-1:0] addr;
    for (i = 0; i < 4; i++) hot_set[i] = SET_W'($urandom_range(2, SETS - 2));
    for (i = 0; i < 3; i++) hot_tag[i] = TAG_W'($urandom);
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 4) act = satc_pkg::ACT_COUNT;
      else if (r < 6) act = ACT_NONE;
      else if (r < 53) act = satc_pkg::ACT_READ;
      else act = satc_pkg::ACT_WRITE;
      if ($urandom_range(0, 99) < 85)
        addr = {hot_tag[$urandom_range(0, 2)], hot_set[$urandom_range(0, 3)],
                OFS_W'($urandom)};
      else
        addr = $urandom;
      push_req(act, addr);
      if (act != ACT_NONE) done++;
    end
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || req_ch.valid || rsp_expected.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [satc_pkg::CFG_IDX_W-1:0] idx,
                           logic [satc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_policies(logic wp, logic [satc_pkg::POL_W-1:0] rp);
    drain();
    write_reg(satc_pkg::CFG_WRITE_POLICY, {1'b0, wp});
    write_reg(satc_pkg::CFG_REPLACE_POLICY, rp);
    n_settings++;
  endtask

  initial begin
    int unsigned i;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    req_ch.valid   = 1'b0;
    req_ch.action  = satc_pkg::ACT_READ;
    req_ch.address = '0;
    rsp_ch.ready   = 1'b0;
    for (i = 0; i < NLINES; i++) begin
      line_tag[i]   = '0;
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_rank[i]  = 3'(i % WAYS);
      line_uses[i]  = '0;
    end
    lfsr     = satc_pkg::LFSR_SEED;
    wr_back  = satc_pkg::WP_THROUGH;
    repl_pol = satc_pkg::POL_LRU;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: write-through, LRU
    push_req(satc_pkg::ACT_READ,  32'h0000_0000);
    push_req(satc_pkg::ACT_READ,  32'h0000_0000);
    push_req(satc_pkg::ACT_WRITE, 32'h0000_0000);
    push_req(satc_pkg::ACT_WRITE, 32'h0000_2000);
    push_req(satc_pkg::ACT_READ,  32'h0000_4000);
    push_req(satc_pkg::ACT_READ,  32'hFFFF_FFFF);
    push_req(satc_pkg::ACT_WRITE, 32'hFFFF_FFC0);
    push_req(satc_pkg::ACT_READ,  32'h8000_0000);
    push_req(satc_pkg::ACT_WRITE, 32'h7FFF_FFFF);
    push_req(satc_pkg::ACT_COUNT, 32'h0000_0000);
    push_req(ACT_NONE,            32'hFFFF_FFFF);
    push_req(ACT_NONE,            32'h0000_0000);
    push_req(satc_pkg::ACT_COUNT, 32'hFFFF_FFFF);
    push_random(PHASE_ITEMS);

    // write-back, LFU: fill set 1 with dirty lines, evict one
    set_policies(satc_pkg::WP_BACK, satc_pkg::POL_LFU);
    push_req(satc_pkg::ACT_WRITE, 32'h0000_0040);
    push_req(satc_pkg::ACT_WRITE, 32'h0000_2040);
    push_req(satc_pkg::ACT_READ,  32'h0000_2040);
    push_req(satc_pkg::ACT_READ,  32'h0000_4040);
    push_req(satc_pkg::ACT_WRITE, 32'h0000_6040);
    push_req(satc_pkg::ACT_COUNT, 32'h0000_0000);
    push_random(PHASE_ITEMS);

    // write-through store evicting a dirty line
    set_policies(satc_pkg::WP_THROUGH, satc_pkg::POL_RANDOM);
    push_req(satc_pkg::ACT_WRITE, 32'h0000_8040);
    push_req(satc_pkg::ACT_READ,  32'h0000_A040);
    push_random(PHASE_ITEMS);

    set_policies(satc_pkg::WP_BACK, satc_pkg::POL_RANDOM);
    push_random(PHASE_ITEMS);
    set_policies(satc_pkg::WP_THROUGH, POL_UNUSED);
    push_random(PHASE_ITEMS);
    set_policies(satc_pkg::WP_BACK, satc_pkg::POL_LRU);
    push_random(PHASE_ITEMS);
    set_policies(satc_pkg::WP_BACK, POL_UNUSED);
    push_random(PHASE_ITEMS);
    set_policies(satc_pkg::WP_THROUGH, satc_pkg::POL_LFU);
    push_random(PHASE_ITEMS);
    drain();
    repeat (10) @(posedge clk_i);

    $display("%0d accesses (%0d hits), %0d dirty counts, %0d policy settings, %0d cycles",
             n_access, n_hits, n_counts, n_settings, cycles);
    $display("%0d dirty victims written back, %0d with a write-through store; %0d errors",
             n_writebacks, n_double, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
